/* rtl/crs_pkg.sv */
// crs_pkg: shared types, codes and decision helpers for the classifier
// reject-and-stabilize block; no dependencies
package crs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PROB_W    = FRAC_BITS + 1;

  typedef logic [PROB_W-1:0] prob_t;
  typedef logic [1:0]        label_t;

  localparam prob_t ONE_Q  = prob_t'(1) << FRAC_BITS;
  localparam prob_t HALF_Q = prob_t'(1) << (FRAC_BITS - 1);

  localparam label_t LABEL_ZERO    = 2'd0;
  localparam label_t LABEL_ONE     = 2'd1;
  localparam label_t LABEL_UNKNOWN = 2'd2;

  localparam logic [1:0] REJ_CONF   = 2'd0;
  localparam logic [1:0] REJ_MARGIN = 2'd1;
  localparam logic [1:0] REJ_BOTH   = 2'd2;
  localparam logic [1:0] REJ_ALIAS  = 2'd3;

  localparam logic [2:0] STAB_VOTE = 3'd0;
  localparam logic [2:0] STAB_AVG  = 3'd1;
  localparam logic [2:0] STAB_EMA  = 3'd2;
  localparam logic [2:0] STAB_HYST = 3'd3;

  localparam logic [2:0] REG_REJ_MODE  = 3'd0;
  localparam logic [2:0] REG_STAB_MODE = 3'd1;
  localparam logic [2:0] REG_CONF_TH   = 3'd2;
  localparam logic [2:0] REG_MARGIN_TH = 3'd3;
  localparam logic [2:0] REG_EMA_W     = 3'd4;
  localparam logic [2:0] REG_CONFIRM   = 3'd5;
  localparam logic [2:0] REG_RELEASE   = 3'd6;

  function automatic prob_t win_conf(input prob_t p);
    return (p >= HALF_Q) ? p : prob_t'(ONE_Q - p);
  endfunction

  // p is already saturated to one
  function automatic label_t decide(input prob_t p, input logic [1:0] mode,
                                    input prob_t conf_th, input prob_t margin_th);
    logic [PROB_W:0] twice;
    logic [PROB_W:0] one_w;
    logic [PROB_W:0] margin;
    logic            fail;
    twice  = {p, 1'b0};
    one_w  = {1'b0, ONE_Q};
    margin = (twice >= one_w) ? (twice - one_w) : (one_w - twice);
    fail   = ((mode != REJ_MARGIN) && (win_conf(p) < conf_th)) ||
             ((mode != REJ_CONF) && (margin < {1'b0, margin_th}));
    if (fail) begin
      return LABEL_UNKNOWN;
    end
    return (p >= HALF_Q) ? LABEL_ONE : LABEL_ZERO;
  endfunction

endpackage

/* rtl/crs_in_if.sv */
// crs_in_if: sample channel, valid/ready with one probability
// depends on crs_pkg
interface crs_in_if;
  import crs_pkg::*;
  logic  valid;
  logic  ready;
  prob_t class_one_probability;
  modport source(output valid, output class_one_probability, input ready);
  modport sink(input valid, input class_one_probability, output ready);
endinterface

/* rtl/crs_out_if.sv */
// crs_out_if: result channel, valid/ready with labels and confidence
// depends on crs_pkg
interface crs_out_if;
  import crs_pkg::*;
  logic   valid;
  logic   ready;
  label_t raw_label;
  label_t stable_label;
  prob_t  winning_confidence;
  modport source(output valid, output raw_label, output stable_label,
                 output winning_confidence, input ready);
  modport sink(input valid, input raw_label, input stable_label,
               input winning_confidence, output ready);
endinterface

/* rtl/classifier_reject_and_stabilize.sv */
// classifier_reject_and_stabilize: two-class rejection with vote, window
// average, ema and hysteresis stabilizers; depends on crs_pkg, crs_in_if, crs_out_if
//
// One sample is taken at a time. After a transaction on samples the block walks the
// filled part of the ring (one entry per cycle, up to WINDOW), runs a restoring
// divider one quotient bit per cycle, uses one shared 17x17 multiplier twice for the
// ema (skipped for the first sample), presents the result and goes back to idle to
// take the next sample. samples.ready is low from the transaction until the block is
// idle again. The result stays in an output register until taken; while it waits
// the next result holds the block in its last step.
module classifier_reject_and_stabilize #(
  parameter int WINDOW = 5
) (
  input  logic            clk,
  input  logic            rst,
  crs_in_if.sink          samples,
  crs_out_if.source       results,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import crs_pkg::*;

  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int LW = $clog2(WINDOW + 1);
  localparam int SW = PROB_W + LW;
  localparam int CW = $clog2(SW + 1);
  localparam int MW = 2 * PROB_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WALK = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL0 = 3'd3;
  localparam logic [2:0] ST_MUL1 = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [1:0] rej_mode;
  logic [2:0] stab_mode;
  prob_t      conf_th, margin_th, ema_w, confirm_lvl, release_lvl;

  logic [2:0] state;
  prob_t      p_reg;
  label_t     raw_reg;
  label_t     label_ring [WINDOW];
  prob_t      prob_ring [WINDOW];
  logic [IW-1:0] wpos;
  logic       ring_full;
  logic [LW-1:0] len;
  logic [CW-1:0] step;
  logic [SW-1:0] quo;
  logic [LW-1:0] rem;
  logic [LW-1:0] cnt0, cnt1, cnt2;
  prob_t      smoothed;
  logic       started;
  logic       ema_go;
  label_t     held;
  logic [MW-1:0] acc;

  logic       out_valid;
  label_t     out_raw, out_stable;
  prob_t      out_conf;

  // apb
  logic       wr_en;
  logic [2:0] reg_idx;
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rej_mode    <= REJ_BOTH;
      stab_mode   <= STAB_AVG;
      conf_th     <= prob_t'(49152);
      margin_th   <= prob_t'(26214);
      ema_w       <= prob_t'(19661);
      confirm_lvl <= prob_t'(45875);
      release_lvl <= prob_t'(29491);
    end else if (wr_en) begin
      case (reg_idx)
        REG_REJ_MODE:  rej_mode    <= (pwdata[1:0] == REJ_ALIAS) ? REJ_BOTH : pwdata[1:0];
        REG_STAB_MODE: stab_mode   <= pwdata[2:0];
        REG_CONF_TH:   conf_th     <= pwdata[PROB_W-1:0];
        REG_MARGIN_TH: margin_th   <= pwdata[PROB_W-1:0];
        REG_EMA_W:     ema_w       <= pwdata[PROB_W-1:0];
        REG_CONFIRM:   confirm_lvl <= pwdata[PROB_W-1:0];
        REG_RELEASE:   release_lvl <= pwdata[PROB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_REJ_MODE:  prdata = {30'd0, rej_mode};
      REG_STAB_MODE: prdata = {29'd0, stab_mode};
      REG_CONF_TH:   prdata = {15'd0, conf_th};
      REG_MARGIN_TH: prdata = {15'd0, margin_th};
      REG_EMA_W:     prdata = {15'd0, ema_w};
      REG_CONFIRM:   prdata = {15'd0, confirm_lvl};
      REG_RELEASE:   prdata = {15'd0, release_lvl};
      default:       prdata = 32'd0;
    endcase
  end

  // input side
  logic   in_acc;
  prob_t  p_sat, conf_in;
  label_t raw_in;
  prob_t  own_in;
  label_t held_next;
  logic   wrap;
  assign samples.ready = (state == ST_IDLE);
  assign in_acc  = samples.valid && samples.ready;
  assign p_sat   = (samples.class_one_probability > ONE_Q) ? ONE_Q
                                                            : samples.class_one_probability;
  assign conf_in = win_conf(p_sat);
  assign raw_in  = decide(p_sat, rej_mode, conf_th, margin_th);
  assign own_in  = (held == LABEL_ONE) ? p_sat : prob_t'(ONE_Q - p_sat);
  assign wrap    = (wpos == IW'(WINDOW - 1));

  always_comb begin
    held_next = held;
    if (held == LABEL_UNKNOWN) begin
      if (raw_in != LABEL_UNKNOWN && conf_in >= confirm_lvl) held_next = raw_in;
    end else if (own_in < release_lvl) begin
      held_next = LABEL_UNKNOWN;
    end else if (raw_in != LABEL_UNKNOWN && raw_in != held && conf_in >= confirm_lvl) begin
      held_next = raw_in;
    end
  end

  // shared datapath
  logic [IW-1:0] idx;
  logic [SW-1:0] sum_next;
  logic [LW:0]   rem_sh;
  logic          qbit;
  prob_t         w_sat, mul_a, mul_b;
  logic [MW-1:0] prod, ema_sum;
  assign idx      = step[IW-1:0];
  assign sum_next = quo + SW'(prob_ring[idx]);
  assign rem_sh   = {rem, quo[SW-1]};
  assign qbit     = (rem_sh >= {1'b0, len});
  assign w_sat    = (ema_w > ONE_Q) ? ONE_Q : ema_w;
  assign mul_a    = (state == ST_MUL0) ? w_sat : prob_t'(ONE_Q - w_sat);
  assign mul_b    = (state == ST_MUL0) ? p_reg : smoothed;
  assign prod     = MW'(mul_a) * MW'(mul_b);
  assign ema_sum  = acc + prod;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      label_ring[wpos] <= raw_in;
      prob_ring[wpos]  <= p_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wpos     <= '0;
      ring_full <= 1'b0;
      smoothed <= HALF_Q;
      started  <= 1'b0;
      held     <= LABEL_UNKNOWN;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            wpos      <= wrap ? '0 : wpos + 1'b1;
            ring_full <= ring_full || wrap;
            held      <= held_next;
            if (!started) begin
              smoothed <= p_sat;
              started  <= 1'b1;
            end
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (step == CW'(len - 1'b1)) state <= ST_DIV;
        end
        ST_DIV: begin
          if (step == CW'(SW - 1)) state <= ema_go ? ST_MUL0 : ST_FIN;
        end
        ST_MUL0: state <= ST_MUL1;
        ST_MUL1: begin
          smoothed <= ema_sum[FRAC_BITS +: PROB_W];
          state    <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid || results.ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        p_reg   <= p_sat;
        raw_reg <= raw_in;
        ema_go  <= started;
        len     <= (ring_full || wrap) ? LW'(WINDOW) : LW'(wpos) + 1'b1;
        step    <= '0;
        quo     <= '0;
        cnt0    <= '0;
        cnt1    <= '0;
        cnt2    <= '0;
      end
      ST_WALK: begin
        if (label_ring[idx] == LABEL_ZERO) cnt0 <= cnt0 + 1'b1;
        if (label_ring[idx] == LABEL_ONE) cnt1 <= cnt1 + 1'b1;
        if (label_ring[idx] == LABEL_UNKNOWN) cnt2 <= cnt2 + 1'b1;
        quo <= sum_next;
        rem <= '0;
        step <= (step == CW'(len - 1'b1)) ? '0 : step + 1'b1;
      end
      ST_DIV: begin
        rem  <= qbit ? LW'(rem_sh - {1'b0, len}) : rem_sh[LW-1:0];
        quo  <= {quo[SW-2:0], qbit};
        step <= step + 1'b1;
      end
      ST_MUL0: acc <= prod;
      default: ;
    endcase
  end

  // result
  label_t vote, stable;
  always_comb begin
    vote = (cnt1 > cnt0) ? LABEL_ONE : LABEL_ZERO;
    if (cnt2 > ((vote == LABEL_ONE) ? cnt1 : cnt0)) vote = LABEL_UNKNOWN;
    case (stab_mode)
      STAB_VOTE: stable = vote;
      STAB_AVG:  stable = decide(quo[PROB_W-1:0], rej_mode, conf_th, margin_th);
      STAB_EMA:  stable = decide(smoothed, rej_mode, conf_th, margin_th);
      STAB_HYST: stable = held;
      default:   stable = raw_reg;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && (!out_valid || results.ready)) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && (!out_valid || results.ready)) begin
      out_raw    <= raw_reg;
      out_stable <= stable;
      out_conf   <= win_conf(p_reg);
    end
  end

  assign results.valid              = out_valid;
  assign results.raw_label          = out_raw;
  assign results.stable_label       = out_stable;
  assign results.winning_confidence = out_conf;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == ST_WALK)
    else $error("no walk after sample transaction");
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK || state == ST_DIV) |-> (len != '0 && len <= LW'(WINDOW)))
    else $error("bad window length");
  a_wpos_range: assert property (@(posedge clk) disable iff (rst)
    wpos <= IW'(WINDOW - 1))
    else $error("ring position out of range");
  a_held_code: assert property (@(posedge clk) disable iff (rst)
    (held != held_next) |-> (in_acc || held_next != LABEL_UNKNOWN || held != LABEL_UNKNOWN))
    else $error("hysteresis changed without sample");
`endif

endmodule

/* tb/tb_classifier_reject_and_stabilize.sv */
// tb_classifier_reject_and_stabilize: directed and random samples through the classifier block,
// checked against a behavioral predictor of rejection and all four stabilizers
// depends on crs_pkg, crs_in_if, crs_out_if and the block itself
module tb_classifier_reject_and_stabilize;
  timeunit 1ns;
  timeprecision 1ps;
  import crs_pkg::*;

  typedef struct packed {
    label_t raw;
    label_t stable;
    prob_t  conf;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  crs_in_if samples();
  crs_out_if results();

  classifier_reject_and_stabilize uut (
    .clk(clk), .rst(rst), .samples(samples), .results(results),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [1:0] rej_mode;
  logic [2:0] stab_mode;
  prob_t conf_th, margin_th, ema_w, confirm_lv, release_lv;
  label_t lbl_ring [5];
  prob_t  p_ring [5];
  int ring_pos = 0;
  bit ring_full = 1'b0;
  logic [63:0] ema_acc = 64'd32768;
  bit ema_seeded = 1'b0;
  label_t held = LABEL_UNKNOWN;

  prob_t sample_queue [$];
  verdict_t verdict_queue [$];
  int errors = 0;
  bit quiet = 1'b0;
  int stall_hold = 0;
  int idle_left = 0;
  bit long_stall_req = 1'b0;
  logic long_stall = 1'b0;

  function automatic label_t classify(logic [63:0] p);
    logic [63:0] c, m;
    c = (p >= 64'd32768) ? p : 64'd65536 - p;
    m = (2 * p >= 64'd65536) ? 2 * p - 64'd65536 : 64'd65536 - 2 * p;
    if (rej_mode != REJ_MARGIN && c < conf_th) return LABEL_UNKNOWN;
    if (rej_mode != REJ_CONF && rej_mode != REJ_MARGIN && m < margin_th) return LABEL_UNKNOWN;
    if (rej_mode == REJ_MARGIN && m < margin_th) return LABEL_UNKNOWN;
    return (p >= 64'd32768) ? LABEL_ONE : LABEL_ZERO;
  endfunction

  function automatic verdict_t predict_verdict(prob_t pin);
    logic [63:0] p, c, w, sum, own;
    int cnt [3];
    int len, best;
    label_t raw, vote, avg, ema, stable;
    verdict_t v;
    p = (pin > 17'd65536) ? 64'd65536 : 64'(pin);
    c = (p >= 64'd32768) ? p : 64'd65536 - p;
    raw = classify(p);
    lbl_ring[ring_pos] = raw;
    p_ring[ring_pos] = prob_t'(p);
    ring_pos = (ring_pos + 1) % 5;
    if (ring_pos == 0) ring_full = 1'b1;
    len = ring_full ? 5 : ring_pos;
    cnt = '{0, 0, 0};
    sum = 0;
    for (int i = 0; i < len; i++) begin
      cnt[lbl_ring[i]]++;
      sum += p_ring[i];
    end
    best = 0;
    for (int i = 1; i < 3; i++) if (cnt[i] > cnt[best]) best = i;
    vote = label_t'(best);
    avg = classify(sum / len);
    if (!ema_seeded) begin
      ema_acc = p;
      ema_seeded = 1'b1;
    end else begin
      w = (ema_w > 17'd65536) ? 64'd65536 : 64'(ema_w);
      ema_acc = (w * p + (64'd65536 - w) * ema_acc) >> 16;
    end
    ema = classify(ema_acc);
    if (held == LABEL_UNKNOWN) begin
      if (raw != LABEL_UNKNOWN && c >= confirm_lv) held = raw;
    end else begin
      own = (held == LABEL_ONE) ? p : 64'd65536 - p;
      if (own < release_lv) held = LABEL_UNKNOWN;
      else if (raw != LABEL_UNKNOWN && raw != held && c >= confirm_lv) held = raw;
    end
    case (stab_mode)
      STAB_VOTE: stable = vote;
      STAB_AVG:  stable = avg;
      STAB_EMA:  stable = ema;
      STAB_HYST: stable = held;
      default:   stable = raw;
    endcase
    v.raw = raw;
    v.stable = stable;
    v.conf = prob_t'(c);
    return v;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      samples.valid <= 1'b0;
      samples.class_one_probability <= '0;
    end else if (!samples.valid || samples.ready) begin
      if (samples.valid) begin
        verdict_queue.push_back(predict_verdict(samples.class_one_probability));
        void'(sample_queue.pop_front());
      end
      if (idle_left > 0) begin
        idle_left--;
        samples.valid <= 1'b0;
      end else if (sample_queue.size() != 0 && (quiet || $urandom_range(0, 3) != 0)) begin
        samples.valid <= 1'b1;
        samples.class_one_probability <= sample_queue[0];
      end else begin
        if (!quiet && sample_queue.size() != 0) idle_left = $urandom_range(0, 2);
        samples.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  initial begin
    wait (long_stall_req);
    @(posedge clk);
    long_stall <= 1'b1;
    repeat (300) @(posedge clk);
    long_stall <= 1'b0;
  end

  // monitor and output stall
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        if (verdict_queue.size() == 0) begin
          $error("unexpected result transaction");
          errors++;
        end else begin
          verdict_t e;
          e = verdict_queue.pop_front();
          if (results.raw_label !== e.raw) begin
            $error("raw_label expected %0d actual %0d", e.raw, results.raw_label);
            errors++;
          end
          if (results.stable_label !== e.stable) begin
            $error("stable_label expected %0d actual %0d", e.stable, results.stable_label);
            errors++;
          end
          if (results.winning_confidence !== e.conf) begin
            $error("winning_confidence expected %0d actual %0d", e.conf,
                   results.winning_confidence);
            errors++;
          end
        end
      end
      if (long_stall) begin
        results.ready <= 1'b0;
      end else if (stall_hold > 0) begin
        stall_hold--;
        results.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_hold = $urandom_range(0, 2);
        results.ready <= 1'b0;
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_REJ_MODE:  rej_mode = (val[1:0] == REJ_ALIAS) ? REJ_BOTH : val[1:0];
      REG_STAB_MODE: stab_mode = val[2:0];
      REG_CONF_TH:   conf_th = val[16:0];
      REG_MARGIN_TH: margin_th = val[16:0];
      REG_EMA_W:     ema_w = val[16:0];
      REG_CONFIRM:   confirm_lv = val[16:0];
      default:       release_lv = val[16:0];
    endcase
  endtask

  task automatic drain();
    while (sample_queue.size() != 0 || verdict_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic prob_t rand_prob();
    case ($urandom_range(0, 5))
      0: return prob_t'($urandom_range(0, 131071));
      1: return prob_t'($urandom_range(0, 4000));
      2: return prob_t'($urandom_range(61536, 65536));
      3: return prob_t'($urandom_range(30000, 35536));
      default: return prob_t'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    rej_mode = REJ_BOTH; stab_mode = STAB_AVG;
    conf_th = 17'd49152; margin_th = 17'd26214; ema_w = 17'd19661;
    confirm_lv = 17'd45875; release_lv = 17'd29491;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, half point, saturation
    sample_queue = '{17'd0, 17'd65536, 17'd32768, 17'd32767, 17'd131071, 17'd65537,
                     17'd1, 17'd65535, 17'd49152, 17'd16384, 17'd45875, 17'd19660};
    drain();
    // long output stall so the block backs up its input
    long_stall_req = 1'b1;
    for (int i = 0; i < 8; i++) sample_queue.push_back(rand_prob());
    drain();
    // directed register corners
    write_reg(REG_REJ_MODE, REJ_ALIAS);
    write_reg(REG_STAB_MODE, 3'd7);
    write_reg(REG_CONF_TH, 32'h1FFFF);
    sample_queue = '{17'd65536, 17'd0, 17'd40000};
    drain();
    write_reg(REG_CONF_TH, 0);
    write_reg(REG_MARGIN_TH, 0);
    write_reg(REG_EMA_W, 32'h1FFFF);
    write_reg(REG_CONFIRM, 0);
    write_reg(REG_RELEASE, 32'h10000);
    for (int m = 0; m < 5; m++) begin
      write_reg(REG_STAB_MODE, m);
      sample_queue = '{17'd0, 17'd65536, 17'd32768, 17'd131071};
      drain();
    end
    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_REJ_MODE, $urandom_range(0, 3));
      write_reg(REG_STAB_MODE, $urandom_range(0, 7));
      write_reg(REG_CONF_TH, (ph % 4 == 0) ? 0 : $urandom_range(30000, 70000));
      write_reg(REG_MARGIN_TH, (ph % 4 == 1) ? 65536 : $urandom_range(0, 70000));
      write_reg(REG_EMA_W, (ph % 4 == 2) ? 0 : $urandom_range(0, 131071));
      write_reg(REG_CONFIRM, $urandom_range(32768, 65536));
      write_reg(REG_RELEASE, (ph == 3) ? 0 : $urandom_range(0, 65536));
      if (ph == 11) quiet = 1'b1;
      for (int i = 0; i < 48; i++) sample_queue.push_back(rand_prob());
      drain();
    end
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #3ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

/* filelist.f */
rtl/crs_pkg.sv
rtl/crs_in_if.sv
rtl/crs_out_if.sv
rtl/classifier_reject_and_stabilize.sv
tb/tb_classifier_reject_and_stabilize.sv
